>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/lstu_pkg.sv
`default_nettype none

package lstu_pkg;

  // Table depth used when the top level is not overridden.
  localparam int NumEntriesDefault = 32;

  // Request action codes.
  localparam logic [1:0] ActRecord = 2'd0;
  localparam logic [1:0] ActClear  = 2'd1;
  localparam logic [1:0] ActRead   = 2'd2;

  localparam int DataW = 64;

  typedef struct packed {
    logic [1:0]       action;
    logic [4:0]       entry_index;
    logic [DataW-1:0] duration;
  } lstu_req_t;

  typedef struct packed {
    logic [DataW-1:0] min_time;
    logic [DataW-1:0] max_time;
    logic [DataW-1:0] mean_time;
    logic [DataW-1:0] total_time;
    logic [DataW-1:0] sample_count;
  } lstu_rsp_t;

  // One table entry as stored in the memory.
  typedef struct packed {
    logic [DataW-1:0] min_v;
    logic [DataW-1:0] max_v;
    logic [DataW-1:0] total_v;
    logic [DataW-1:0] count_v;
  } lstu_entry_t;

  localparam lstu_entry_t EmptyEntry = '{
    min_v:   {DataW{1'b1}},
    max_v:   '0,
    total_v: '0,
    count_v: '0
  };

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;
    logic clear;
    logic update;
    logic load;
    logic div_start;
    logic load_out;
  } lstu_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0] in_action;
    logic       count_zero;
    logic       div_done;
  } lstu_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/lstu_div.sv
`default_nettype none

module lstu_div import lstu_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DataW-1:0] dividend_i,
  input  wire logic [DataW-1:0] divisor_i,
  output logic                  done_o,
  output logic [DataW-1:0]      quotient_o
);

  localparam int DivSteps = DataW;
  localparam int CntW     = $clog2(DivSteps);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DataW-1:0] rem_q;
  logic [DataW-1:0] quo_q;
  logic [DataW-1:0] den_q;

  logic [DataW:0]   rem_sh;
  logic [DataW+1:0] diff;
  logic             borrow;

  // Shift in the next dividend bit and trial-subtract the divisor.
  assign rem_sh = {rem_q, quo_q[DataW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
  assign borrow = diff[DataW+1];

  // Step control: one quotient bit per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CntW'(DivSteps - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      if (borrow) begin
        rem_q <= rem_sh[DataW-1:0];
        quo_q <= {quo_q[DataW-2:0], 1'b0};
      end else begin
        rem_q <= diff[DataW-1:0];
        quo_q <= {quo_q[DataW-2:0], 1'b1};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> rtl/core/lstu_datapath.sv
`default_nettype none

module lstu_datapath import lstu_pkg::*; #(
  parameter int NumEntries = NumEntriesDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire lstu_req_t in_req_i,
  input  wire lstu_cmd_t cmd_i,
  output lstu_sts_t      sts_o,
  output lstu_rsp_t      out_rsp_o
);

  localparam int IdxW = (NumEntries > 1) ? $clog2(NumEntries) : 1;

  lstu_entry_t mem_q [NumEntries];
  logic [NumEntries-1:0] vld_q;

  lstu_req_t        req_q;
  logic [IdxW-1:0]  addr_q;
  logic             range_q;
  logic             ok_q;
  lstu_entry_t      rd_q;
  lstu_entry_t      cur_q;
  lstu_rsp_t        out_q;

  logic [IdxW-1:0]  in_addr;
  logic             in_range;
  lstu_entry_t      cur_entry;
  lstu_entry_t      upd_entry;
  logic [DataW-1:0] quotient;
  logic             div_done;
  logic             count_zero;

  assign in_addr  = IdxW'(in_req_i.entry_index);
  assign in_range = 32'(in_req_i.entry_index) < NumEntries;

  // Capture the request and read its entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q   <= in_req_i;
      addr_q  <= in_addr;
      range_q <= in_range;
      ok_q    <= in_range && vld_q[in_addr];
      rd_q    <= mem_q[in_addr];
    end
  end

  // An entry not written since reset or clear reads as empty.
  assign cur_entry = ok_q ? rd_q : EmptyEntry;

  // Fold one duration into the entry.
  always_comb begin
    upd_entry         = cur_entry;
    upd_entry.total_v = cur_entry.total_v + req_q.duration;
    upd_entry.count_v = cur_entry.count_v + 1'b1;
    if (req_q.duration < cur_entry.min_v) begin
      upd_entry.min_v = req_q.duration;
    end
    if (req_q.duration > cur_entry.max_v) begin
      upd_entry.max_v = req_q.duration;
    end
  end

  // Write back the updated entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update && range_q) begin
      mem_q[addr_q] <= upd_entry;
    end
  end

  // Track which entries hold data; clear drops them all at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.clear) begin
      vld_q <= '0;
    end else if (cmd_i.update && range_q) begin
      vld_q[addr_q] <= 1'b1;
    end
  end

  // Hold the entry being read while the mean is computed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q <= cur_entry;
    end
  end

  assign count_zero = (cur_q.count_v == '0);

  lstu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cur_q.total_v),
    .divisor_i  (cur_q.count_v),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.min_time     <= cur_q.min_v;
      out_q.max_time     <= cur_q.max_v;
      out_q.mean_time    <= count_zero ? '0 : quotient;
      out_q.total_time   <= cur_q.total_v;
      out_q.sample_count <= cur_q.count_v;
    end
  end

  assign sts_o.in_action  = in_req_i.action;
  assign sts_o.count_zero = count_zero;
  assign sts_o.div_done   = div_done;
  assign out_rsp_o        = out_q;

endmodule

`default_nettype wire

>>> rtl/core/lstu_ctrl.sv
`default_nettype none

module lstu_ctrl import lstu_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  input  wire lstu_sts_t sts_i,
  output lstu_cmd_t      cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_UPDATE = 6'b000010,
    ST_LOAD   = 6'b000100,
    ST_START  = 6'b001000,
    ST_WAIT   = 6'b010000,
    ST_FINISH = 6'b100000
  } lstu_state_e;

  lstu_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_take;

  assign out_take = out_valid_q && !out_stall_i;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_take;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (sts_i.in_action)
            ActRecord: state_d = ST_UPDATE;
            ActClear:  cmd_o.clear = 1'b1;
            ActRead:   state_d = ST_LOAD;
            default:   ;
          endcase
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_START;
      end
      ST_START: begin
        // Skip the divider for an empty count.
        if (sts_i.count_zero) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/core/latency_statistics_table_unit.sv
// Per-category latency statistics table.
// Input channel (in_valid_i / in_stall_o, payload in_req_i): record adds a
// duration to one entry, clear empties every entry, read returns one entry.
// Output channel (out_valid_o / out_stall_i, payload out_rsp_o): one response
// per read, with min, max, mean, total and count; nothing for other actions.
// A record reads its entry, then writes it back; a clear completes as it is
// accepted. A read goes from request to response through load, divider
// start, the one-bit-per-cycle mean divider, a step to see it finish,
// then the output register; with a zero count the divider is skipped.
// A request is taken only while the controller is idle; the
// output register lets the next request in while a response still waits.
// Reset empties the table at once through per-entry valid bits, so the block
// is ready as soon as reset is released. While out_stall_i holds a response,
// the response stays put and a following read waits before its last step.
`default_nettype none

module latency_statistics_table_unit import lstu_pkg::*; #(
  parameter int NumEntries = NumEntriesDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire lstu_req_t in_req_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output lstu_rsp_t      out_rsp_o
);

  lstu_cmd_t cmd;
  lstu_sts_t sts;

  lstu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lstu_datapath #(
    .NumEntries (NumEntries)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_rsp_o (out_rsp_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/lstu_checker.sv
`default_nettype none

`include "assert_macros.svh"

module lstu_checker import lstu_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire lstu_req_t in_req_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire lstu_rsp_t out_rsp_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // A stalled response holds.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_rsp_o), "stalled response changed")

  // A record request blocks the next request while it writes back.
  `ASSERT_NEXT(a_record_stall, clk_i, rst_ni, in_acc && (in_req_i.action == ActRecord), in_stall_o, "record did not stall input")

  // Only a read produces a response; no response rises in the cycle after any request.
  `ASSERT_NEXT(a_no_early_rsp, clk_i, rst_ni, in_acc, !$rose(out_valid_o), "response appeared right after request")

  // The mean never exceeds the total, and is zero for an empty count.
  `ASSERT_IMPL(a_mean_bound, clk_i, rst_ni, out_valid_o, (out_rsp_o.mean_time <= out_rsp_o.total_time) && ((out_rsp_o.sample_count != '0) || (out_rsp_o.mean_time == '0)), "mean out of range")

endmodule

bind latency_statistics_table_unit lstu_checker u_checker (.*);

`default_nettype wire
